// ===== src/cmta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmta_pkg: shared definitions for the cube map texel address unit
// Default sizes, register indexes, face codes and the control bundle that
// travels down the pipeline next to the arithmetic payload.
// ----------------------------------------------------------------------------
package cmta_pkg;

   // Default parameter values
   localparam int COMPONENT_BITS_DEF = 16;
   localparam int MAX_FACE_SIZE_DEF  = 4096;

   // Register port
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACE_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  FACE_SIZE_RESET = 13'd512;

   // Result widths
   localparam int FACE_W  = 3;
   localparam int TEXEL_W = 12;

   // Face codes
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   // Per-item control bundle
   typedef struct packed {
      logic              valid;
      logic [FACE_W-1:0] face;
      logic              zero;
   } ctrl_type;

endpackage

// ===== src/cmta_face_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmta_face_sel: major axis and face coordinate stages
// Stage 1 takes absolute values of the three components. Stage 2 picks the
// major axis, the face, and forms the offset coordinates s+ma and t+ma.
// ----------------------------------------------------------------------------
module cmta_face_sel
   import cmta_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [COMPONENT_BITS-1:0] in_x,
   input  logic [COMPONENT_BITS-1:0] in_y,
   input  logic [COMPONENT_BITS-1:0] in_z,
   output ctrl_type                  ctrl_out,
   output logic [COMPONENT_BITS-1:0] ma_out,
   output logic [COMPONENT_BITS:0]   sum_s_out,
   output logic [COMPONENT_BITS:0]   sum_t_out
);

   localparam int N = COMPONENT_BITS;

   // Offset a signed component (optionally negated) by the major magnitude
   function automatic logic [N:0] offset_coord(input logic [N-1:0] c, input logic neg,
                                               input logic [N-1:0] ma);
      logic signed [N+1:0] cw;
      logic signed [N+1:0] tot;
      cw = $signed({{2{c[N-1]}}, c});
      if (neg) begin
         cw = -cw;
      end
      tot = cw + $signed({2'b00, ma});
      return tot[N:0];
   endfunction

   // Stage 1 registers
   logic         v1_ff;
   logic [N-1:0] x1_ff, y1_ff, z1_ff;
   logic [N-1:0] ax1_ff, ay1_ff, az1_ff;
   logic [N-1:0] ax1_in, ay1_in, az1_in;

   // Stage 2 registers
   ctrl_type     ctrl2_ff, ctrl2_in;
   logic [N-1:0] ma2_ff, ma2_in;
   logic [N:0]   sum_s2_ff, sum_s2_in;
   logic [N:0]   sum_t2_ff, sum_t2_in;

   // Take magnitudes
   always_comb begin
      ax1_in = in_x[N-1] ? (~in_x + 1'b1) : in_x;
      ay1_in = in_y[N-1] ? (~in_y + 1'b1) : in_y;
      az1_in = in_z[N-1] ? (~in_z + 1'b1) : in_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      x1_ff  <= in_x;
      y1_ff  <= in_y;
      z1_ff  <= in_z;
      ax1_ff <= ax1_in;
      ay1_ff <= ay1_in;
      az1_ff <= az1_in;
   end

   // Pick major axis, face and offset coordinates; ties go to z, then y
   always_comb begin
      ctrl2_in.valid = v1_ff;
      ctrl2_in.zero  = (ax1_ff == '0) && (ay1_ff == '0) && (az1_ff == '0);
      if ((ax1_ff > ay1_ff) && (ax1_ff > az1_ff)) begin
         ma2_in = ax1_ff;
         sum_t2_in = offset_coord(y1_ff, 1'b0, ax1_ff);
         if (!x1_ff[N-1]) begin
            ctrl2_in.face = FACE_POS_X;
            sum_s2_in = offset_coord(z1_ff, 1'b0, ax1_ff);
         end else begin
            ctrl2_in.face = FACE_NEG_X;
            sum_s2_in = offset_coord(z1_ff, 1'b1, ax1_ff);
         end
      end else if (ay1_ff > az1_ff) begin
         ma2_in = ay1_ff;
         sum_s2_in = offset_coord(x1_ff, 1'b0, ay1_ff);
         if (!y1_ff[N-1]) begin
            ctrl2_in.face = FACE_POS_Y;
            sum_t2_in = offset_coord(z1_ff, 1'b0, ay1_ff);
         end else begin
            ctrl2_in.face = FACE_NEG_Y;
            sum_t2_in = offset_coord(z1_ff, 1'b1, ay1_ff);
         end
      end else begin
         ma2_in = az1_ff;
         sum_t2_in = offset_coord(y1_ff, 1'b0, az1_ff);
         if (!z1_ff[N-1] && (az1_ff != '0)) begin
            ctrl2_in.face = FACE_POS_Z;
            sum_s2_in = offset_coord(x1_ff, 1'b1, az1_ff);
         end else begin
            ctrl2_in.face = FACE_NEG_Z;
            sum_s2_in = offset_coord(x1_ff, 1'b0, az1_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else begin
         ctrl2_ff <= ctrl2_in;
      end
      ma2_ff    <= ma2_in;
      sum_s2_ff <= sum_s2_in;
      sum_t2_ff <= sum_t2_in;
   end

   assign ctrl_out  = ctrl2_ff;
   assign ma_out    = ma2_ff;
   assign sum_s_out = sum_s2_ff;
   assign sum_t_out = sum_t2_ff;

endmodule

// ===== src/cmta_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmta_div_pipe: two-lane pipelined restoring divider
// An input register stage, then one quotient bit per stage, most significant
// first. Both lanes share one divisor. The caller guarantees that the
// quotient fits in QBITS bits.
// ----------------------------------------------------------------------------
module cmta_div_pipe
   import cmta_pkg::*;
#(
   parameter int NUM_W = 30,
   parameter int DEN_W = 17,
   parameter int QBITS = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl_in,
   input  logic [NUM_W-1:0] num_a,
   input  logic [NUM_W-1:0] num_b,
   input  logic [DEN_W-1:0] den,
   output ctrl_type         ctrl_out,
   output logic [QBITS-1:0] quo_a,
   output logic [QBITS-1:0] quo_b
);

   ctrl_type         ctrl_ff  [0:QBITS];
   logic [NUM_W-1:0] rem_a_ff [0:QBITS-1];
   logic [NUM_W-1:0] rem_b_ff [0:QBITS-1];
   logic [DEN_W-1:0] den_ff   [0:QBITS-1];
   logic [QBITS-1:0] quo_a_ff [1:QBITS];
   logic [QBITS-1:0] quo_b_ff [1:QBITS];

   // Capture the dividends and divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff[0] <= '0;
      end else begin
         ctrl_ff[0] <= ctrl_in;
      end
      rem_a_ff[0] <= num_a;
      rem_b_ff[0] <= num_b;
      den_ff[0]   <= den;
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      localparam int B = QBITS - 1 - k;

      logic [NUM_W-1:0] shifted;
      logic [QBITS-1:0] quo_a_prev, quo_b_prev;
      logic [QBITS-1:0] quo_a_in, quo_b_in;
      logic [NUM_W-1:0] rem_a_in, rem_b_in;
      logic             take_a, take_b;

      if (k == 0) begin : g_first
         assign quo_a_prev = '0;
         assign quo_b_prev = '0;
      end else begin : g_rest
         assign quo_a_prev = quo_a_ff[k];
         assign quo_b_prev = quo_b_ff[k];
      end

      // Try to subtract the aligned divisor in each lane
      always_comb begin
         shifted  = NUM_W'(den_ff[k]) << B;
         take_a   = rem_a_ff[k] >= shifted;
         take_b   = rem_b_ff[k] >= shifted;
         rem_a_in = take_a ? (rem_a_ff[k] - shifted) : rem_a_ff[k];
         rem_b_in = take_b ? (rem_b_ff[k] - shifted) : rem_b_ff[k];
         quo_a_in = quo_a_prev | (QBITS'(take_a) << B);
         quo_b_in = quo_b_prev | (QBITS'(take_b) << B);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[k+1] <= '0;
         end else begin
            ctrl_ff[k+1] <= ctrl_ff[k];
         end
         quo_a_ff[k+1] <= quo_a_in;
         quo_b_ff[k+1] <= quo_b_in;
      end

      // Hand the remainder on, except after the last bit
      if (k < QBITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_a_ff[k+1] <= rem_a_in;
            rem_b_ff[k+1] <= rem_b_in;
            den_ff[k+1]   <= den_ff[k];
         end
      end
   end

   assign ctrl_out = ctrl_ff[QBITS];
   assign quo_a    = quo_a_ff[QBITS];
   assign quo_b    = quo_b_ff[QBITS];

endmodule

// ===== src/cube_map_texel_address.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_texel_address: cube map face and texel address unit
// Picks the cube face of a signed direction vector and gives the texel
// column and row floor((c+ma)*size/(2*ma)) on that face, wrapped below size.
//
//   channel   ports                          handshake
//   request   req_dir_x/y/z                  start & !busy
//   response  rsp_face/texel_col/texel_row/  rsp_strobe, one cycle
//             rsp_zero_direction
//   config    csr_index, csr_wdata           csr_write_en
//
// One item per cycle, every cycle; busy stays low. The divider resolves one
// quotient bit per stage after its input register; the face select takes two
// stages and the wrap/output stage one more.
// Reset clears the valid bits and loads both face sizes with 512.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module cube_map_texel_address
   import cmta_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int MAX_FACE_SIZE  = MAX_FACE_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [COMPONENT_BITS-1:0] req_dir_x,
   input  logic [COMPONENT_BITS-1:0] req_dir_y,
   input  logic [COMPONENT_BITS-1:0] req_dir_z,
   output logic                      rsp_strobe,
   output logic [FACE_W-1:0]         rsp_face,
   output logic [TEXEL_W-1:0]        rsp_texel_col,
   output logic [TEXEL_W-1:0]        rsp_texel_row,
   output logic                      rsp_zero_direction,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int N         = COMPONENT_BITS;
   localparam int SIZE_BITS = $clog2(MAX_FACE_SIZE + 1);
   localparam int CMP_W     = (SIZE_BITS > CSR_DATA_W) ? SIZE_BITS : CSR_DATA_W;
   localparam int NUM_W     = N + 1 + SIZE_BITS;
   localparam int DEN_W     = N + 1;

   // Configuration registers
   logic [CSR_DATA_W-1:0] face_width_ff, face_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff  <= FACE_SIZE_RESET;
         face_height_ff <= FACE_SIZE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FACE_WIDTH: begin
               face_width_ff <= csr_wdata;
            end
            CSR_FACE_HEIGHT: begin
               face_height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the face sizes to the largest supported face
   logic [CMP_W-1:0]     width_wide, height_wide;
   logic [SIZE_BITS-1:0] eff_width, eff_height;

   always_comb begin
      width_wide  = CMP_W'(face_width_ff);
      height_wide = CMP_W'(face_height_ff);
      eff_width   = (width_wide > CMP_W'(MAX_FACE_SIZE)) ?
                    SIZE_BITS'(MAX_FACE_SIZE) : SIZE_BITS'(width_wide);
      eff_height  = (height_wide > CMP_W'(MAX_FACE_SIZE)) ?
                    SIZE_BITS'(MAX_FACE_SIZE) : SIZE_BITS'(height_wide);
   end

   // Always ready: an item enters every cycle
   assign busy = 1'b0;

   // Face select stages
   ctrl_type   sel_ctrl;
   logic [N-1:0] sel_ma;
   logic [N:0]   sel_sum_s, sel_sum_t;

   cmta_face_sel #(
      .COMPONENT_BITS(COMPONENT_BITS)
   ) u_face_sel (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_x     (req_dir_x),
      .in_y     (req_dir_y),
      .in_z     (req_dir_z),
      .ctrl_out (sel_ctrl),
      .ma_out   (sel_ma),
      .sum_s_out(sel_sum_s),
      .sum_t_out(sel_sum_t)
   );

   // Scale the offset coordinates by the face size; the divider registers them
   logic [NUM_W-1:0] num_s, num_t;
   logic [DEN_W-1:0] den;

   always_comb begin
      num_s = NUM_W'(sel_sum_s) * NUM_W'(eff_width);
      num_t = NUM_W'(sel_sum_t) * NUM_W'(eff_height);
      den   = {sel_ma, 1'b0};
   end

   ctrl_type             div_ctrl;
   logic [SIZE_BITS-1:0] quo_s, quo_t;

   cmta_div_pipe #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W),
      .QBITS(SIZE_BITS)
   ) u_div_pipe (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (sel_ctrl),
      .num_a   (num_s),
      .num_b   (num_t),
      .den     (den),
      .ctrl_out(div_ctrl),
      .quo_a   (quo_s),
      .quo_b   (quo_t)
   );

   // Wrap at the face edge, force the zero vector result, register the output
   logic                         strobe_ff, strobe_in;
   logic [FACE_W-1:0]            face_ff, face_in;
   logic [TEXEL_W-1:0]           col_ff, col_in;
   logic [TEXEL_W-1:0]           row_ff, row_in;
   logic                         zero_ff, zero_in;
   logic [SIZE_BITS+TEXEL_W-1:0] col_wide, row_wide;

   always_comb begin
      col_wide  = (quo_s >= eff_width)  ? '0 : {{TEXEL_W{1'b0}}, quo_s};
      row_wide  = (quo_t >= eff_height) ? '0 : {{TEXEL_W{1'b0}}, quo_t};
      strobe_in = div_ctrl.valid;
      zero_in   = div_ctrl.zero;
      if (div_ctrl.zero) begin
         face_in = FACE_NEG_Z;
         col_in  = '0;
         row_in  = '0;
      end else begin
         face_in = div_ctrl.face;
         col_in  = col_wide[TEXEL_W-1:0];
         row_in  = row_wide[TEXEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      face_ff <= face_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      zero_ff <= zero_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_face           = face_ff;
   assign rsp_texel_col      = col_ff;
   assign rsp_texel_row      = row_ff;
   assign rsp_zero_direction = zero_ff;

endmodule
